### hw/rtl/usan_pkg.sv
// ---------------------------------------------------------------------------
// usan_pkg: shared types and constants for the UTF-8 name sanitizer
// Transaction structs, queued job format and character codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package usan_pkg;

  localparam int unsigned MaxResults = 5;

  localparam logic [7:0] CharBackslash  = 8'h5C;
  localparam logic [7:0] CharNewline    = 8'h0A;
  localparam logic [7:0] CharPipe       = 8'h7C;
  localparam logic [7:0] CharUnderscore = 8'h5F;
  localparam logic [7:0] CharLetterN    = 8'h6E;
  localparam logic [7:0] CharDel        = 8'h7F;

  localparam logic [20:0] CpMax      = 21'h10FFFF;
  localparam logic [20:0] CpSurrLow  = 21'h00D800;
  localparam logic [20:0] CpSurrHigh = 21'h00DFFF;
  localparam logic [20:0] CpMin2     = 21'h000080;
  localparam logic [20:0] CpMin3     = 21'h000800;
  localparam logic [20:0] CpMin4     = 21'h010000;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       name_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_item_t;

  // All output bytes caused by one input transaction.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [2:0]                 count;
    logic                       name_end;
  } job_t;

endpackage

### hw/rtl/usan_front.sv
// ---------------------------------------------------------------------------
// usan_front: byte classifier and UTF-8 sequence tracker
// Accepts one byte per cycle while in_fire_i is set and builds the job of output bytes it causes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module usan_front import usan_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_fire_i,
  input  in_item_t in_data_i,
  output logic     push_o,
  output job_t     job_o
);

  logic [7:0]  hb_q [3];
  logic [7:0]  hb_d [3];
  logic [1:0]  held_q, held_d;
  logic [2:0]  seq_q, seq_d;
  logic [20:0] cp_q, cp_d;

  logic [7:0]  b;
  logic        name_last;
  logic        cont;
  logic [7:0]  fr0, fr1;
  logic [1:0]  fr_n;
  logic        fr_hold;
  logic [2:0]  fr_len;
  logic [20:0] cp_init, cp_next;
  logic [2:0]  total;
  logic [20:0] cp_min;
  logic        cp_ok;
  logic        start_fresh;
  logic [1:0]  pfx;
  logic [2:0]  rel;

  assign b         = in_data_i.in_byte;
  assign name_last = in_data_i.name_end;
  assign cont      = (b[7:6] == 2'b10);
  assign cp_next   = {cp_q[14:0], b[5:0]};
  assign total     = {1'b0, held_q} + 3'd1;

  // Byte with nothing held.
  always_comb begin
    fr0     = CharUnderscore;
    fr1     = CharUnderscore;
    fr_n    = 2'd1;
    fr_hold = 1'b0;
    fr_len  = 3'd2;
    if (b == CharBackslash) begin
      fr0  = CharBackslash;
      fr1  = CharBackslash;
      fr_n = 2'd2;
    end else if (b == CharNewline) begin
      fr0  = CharBackslash;
      fr1  = CharLetterN;
      fr_n = 2'd2;
    end else if (b inside {[8'h00:8'h1F], CharPipe, CharDel}) begin
      fr0 = CharUnderscore;
    end else if (b < 8'h80) begin
      fr0 = b;
    end else if (b >= 8'hC0 && b < 8'hF8 && !name_last) begin
      fr_n    = 2'd0;
      fr_hold = 1'b1;
      if (b >= 8'hF0) begin
        fr_len = 3'd4;
      end else if (b >= 8'hE0) begin
        fr_len = 3'd3;
      end else begin
        fr_len = 3'd2;
      end
    end
  end

  assign cp_init = 21'(b & (8'h7F >> fr_len));

  always_comb begin
    case (seq_q)
      3'd2:    cp_min = CpMin2;
      3'd3:    cp_min = CpMin3;
      default: cp_min = CpMin4;
    endcase
    cp_ok = (cp_next >= cp_min) && (cp_next <= CpMax) &&
            !((cp_next >= CpSurrLow) && (cp_next <= CpSurrHigh));
  end

  always_comb begin
    job_o.bytes    = {MaxResults{CharUnderscore}};
    job_o.count    = 3'd0;
    job_o.name_end = name_last;
    hb_d           = hb_q;
    held_d         = held_q;
    seq_d          = seq_q;
    cp_d           = cp_q;
    start_fresh    = 1'b0;
    pfx            = 2'd0;
    rel            = 3'd0;

    if (held_q != 2'd0) begin
      if (cont) begin
        if (total >= seq_q) begin
          if (cp_ok) begin
            for (int k = 0; k < 3; k++) begin
              job_o.bytes[k] = hb_q[k];
            end
            job_o.bytes[3'(held_q)] = b;
          end
          job_o.count = total;
          held_d = 2'd0;
          seq_d  = 3'd0;
          cp_d   = '0;
        end else if (name_last || held_q == 2'd3) begin
          job_o.count = total;
          held_d = 2'd0;
          seq_d  = 3'd0;
          cp_d   = '0;
        end else begin
          hb_d[held_q] = b;
          held_d = held_q + 2'd1;
          cp_d   = cp_next;
        end
      end else begin
        // interrupted sequence: one underscore per held byte, then the new byte
        pfx         = held_q;
        held_d      = 2'd0;
        seq_d       = 3'd0;
        cp_d        = '0;
        start_fresh = 1'b1;
      end
    end else begin
      start_fresh = 1'b1;
    end

    if (start_fresh) begin
      for (int k = 0; k < MaxResults; k++) begin
        rel = 3'(k) - {1'b0, pfx};
        if (3'(k) >= {1'b0, pfx}) begin
          job_o.bytes[k] = (rel == 3'd0) ? fr0 : fr1;
        end
      end
      job_o.count = {1'b0, pfx} + {1'b0, fr_n};
      if (fr_hold) begin
        hb_d[0] = b;
        held_d  = 2'd1;
        seq_d   = fr_len;
        cp_d    = cp_init;
      end
    end

    if (name_last) begin
      held_d = 2'd0;
      seq_d  = 3'd0;
      cp_d   = '0;
    end
  end

  assign push_o = in_fire_i && (job_o.count != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 2'd0;
      seq_q  <= 3'd0;
      cp_q   <= '0;
    end else if (in_fire_i) begin
      held_q <= held_d;
      seq_q  <= seq_d;
      cp_q   <= cp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      hb_q <= hb_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q != 2'd0) |-> (seq_q >= 3'd2 && seq_q <= 3'd4 && {1'b0, held_q} < seq_q))
    else $error("held byte count out of step with sequence length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_i && in_data_i.name_end) |=> (held_q == 2'd0 && cp_q == '0))
    else $error("sequence state not cleared after end of name");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_i && in_data_i.name_end) |-> push_o)
    else $error("final byte of a name produced no output");
`endif

endmodule

### hw/rtl/usan_fifo.sv
// ---------------------------------------------------------------------------
// usan_fifo: two-entry job queue
// Decouples the classifier from the output serializer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module usan_fifo import usan_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hw/rtl/usan_back.sv
// ---------------------------------------------------------------------------
// usan_back: output serializer
// Emits the queued job's bytes through an output register, one per cycle while the receiver is ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module usan_back import usan_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  job_t      head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic [2:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_data_q;
  logic       load;
  logic       last_byte;

  assign load      = head_valid_i && (!out_valid_q || out_ready_i);
  assign last_byte = (idx_q == head_i.count - 3'd1);
  assign pop_o     = load && last_byte;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = last_byte ? 3'd0 : idx_q + 3'd1;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q.out_byte   <= head_i.bytes[idx_q];
      out_data_q.run_last   <= last_byte;
      out_data_q.string_end <= last_byte && head_i.name_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### hw/rtl/utf8_sanitize_escape.sv
// ---------------------------------------------------------------------------
// utf8_sanitize_escape: UTF-8 name sanitizer with escapes
// Streams a name byte by byte and emits a cleaned, escaped byte stream.
// ---------------------------------------------------------------------------
// A name enters one byte per input transaction, name_end set on its last
// byte. Backslash becomes two backslashes, newline becomes backslash and 'n';
// pipe, other control bytes and DEL become '_'; other ASCII passes. A
// multi-byte UTF-8 sequence is held and released intact once complete and
// valid; a broken, overlong, surrogate, out-of-range or truncated sequence
// turns into one '_' per byte, and lead bytes 0xF8 and above are invalid.
// Each input byte causes 0 to 5 output transactions; run_last marks the last
// one of an input, string_end the last one of a name. Input is taken one
// byte per cycle. Output runs at one byte per cycle while the receiver is
// ready; the two-entry job queue between the classifier and the serializer
// absorbs multi-byte results, and input stalls only when the queue is full.
// A job is registered in the queue, then leaves through the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_sanitize_escape import usan_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic in_fire;
  logic push;
  job_t job;
  logic q_full;
  logic q_valid;
  job_t q_head;
  logic q_pop;

  // Input is accepted whenever the queue has room, regardless of output stalls.
  assign in_ready_o = !q_full;
  assign in_fire    = in_valid_i && in_ready_o;

  // Front: classify the byte, track held sequence state, build the job.
  usan_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .in_data_i (in_data_i),
    .push_o    (push),
    .job_o     (job)
  );

  // Jobs with no output bytes (held lead/continuation) are never queued.
  usan_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_head)
  );

  // Back: walk the head job byte by byte into the output register.
  usan_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

### tb/tb_utf8_sanitize_escape.sv
// ---------------------------------------------------------------------------
// tb_utf8_sanitize_escape: self-checking bench for the UTF-8 name sanitizer
// Streams names through the block with random bursts and output stalls,
// predicts every escaped or sanitized byte and checks each output
// transaction against the oldest predicted byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_utf8_sanitize_escape;
  import usan_pkg::*;

  localparam int ClkHalf      = 6;       // 12 ns period
  localparam int ResetCycles  = 4;
  localparam int NumItems     = 180;     // directed bytes count toward this
  localparam int DrainCycles  = 24;      // margin for the job queue and the output register
  localparam int CycleLimit   = 200000;

  // UTF-8 lead byte boundaries and ASCII class limits
  localparam logic [7:0] LeadTwo     = 8'hC0;
  localparam logic [7:0] LeadThree   = 8'hE0;
  localparam logic [7:0] LeadFour    = 8'hF0;
  localparam logic [7:0] LeadInvalid = 8'hF8;
  localparam logic [7:0] CtrlLimit   = 8'h20;
  localparam logic [7:0] AsciiLimit  = 8'h80;
  localparam logic [7:0] ContBase    = 8'h80;

  // Output stall modes of the receiver
  typedef enum logic [1:0] {
    RxFree,
    RxRandom,
    RxPeriodic
  } rx_mode_e;

  // -------------------------------------------------------------------------
  // Byte predictor: mirrors the sequence holding state of the block and keeps
  // the queue of output bytes still owed by the DUT.
  // -------------------------------------------------------------------------
  class escape_tracker;
    logic [7:0]  seq_buf [3];
    logic [1:0]  seq_cnt;
    logic [2:0]  seq_len;
    logic [20:0] cp_acc;
    out_item_t   owed_bytes [$];
    int          fails;

    function new();
      seq_cnt = '0;
      seq_len = '0;
      cp_acc  = '0;
      fails   = 0;
    endfunction

    function int pending();
      return owed_bytes.size();
    endfunction

    // Accepted input transaction: work out every byte it releases.
    function void take_byte(in_item_t item);
      logic [7:0]  run_q [$];
      logic [7:0]  b;
      logic [20:0] cp_floor;
      logic        fin;
      logic        consumed;
      out_item_t   ent;
      int          total;
      int          k;

      b        = item.in_byte;
      fin      = item.name_end;
      consumed = 1'b0;

      if (seq_cnt != 0) begin
        if (b[7:6] == 2'b10) begin
          total  = int'(seq_cnt) + 1;
          cp_acc = {cp_acc[14:0], b[5:0]};
          if (total >= int'(seq_len)) begin
            cp_floor = (seq_len == 3'd2) ? CpMin2 : (seq_len == 3'd3) ? CpMin3 : CpMin4;
            if (cp_acc < cp_floor || cp_acc > CpMax ||
                (cp_acc >= CpSurrLow && cp_acc <= CpSurrHigh)) begin
              // overlong, surrogate or beyond the code space
              repeat (total) run_q.insert(run_q.size(), CharUnderscore);
            end else begin
              for (k = 0; k < int'(seq_cnt); k++) run_q.insert(run_q.size(), seq_buf[k]);
              run_q.insert(run_q.size(), b);
            end
            seq_cnt = '0; seq_len = '0; cp_acc = '0;
          end else if (fin || seq_cnt == 2'd3) begin
            // name ends inside the sequence
            repeat (total) run_q.insert(run_q.size(), CharUnderscore);
            seq_cnt = '0; seq_len = '0; cp_acc = '0;
          end else begin
            seq_buf[seq_cnt] = b;
            seq_cnt++;
            return;
          end
          consumed = 1'b1;
        end else begin
          // interrupted: flush held bytes, then treat b as fresh
          repeat (int'(seq_cnt)) run_q.insert(run_q.size(), CharUnderscore);
          seq_cnt = '0; seq_len = '0; cp_acc = '0;
        end
      end

      if (!consumed) begin
        if (b == CharBackslash) begin
          run_q.insert(run_q.size(), CharBackslash);
          run_q.insert(run_q.size(), CharBackslash);
        end else if (b == CharNewline) begin
          run_q.insert(run_q.size(), CharBackslash);
          run_q.insert(run_q.size(), CharLetterN);
        end else if (b == CharPipe || b < CtrlLimit || b == CharDel) begin
          run_q.insert(run_q.size(), CharUnderscore);
        end else if (b < AsciiLimit) begin
          run_q.insert(run_q.size(), b);
        end else if (b >= LeadTwo && b < LeadInvalid && !fin) begin
          seq_buf[0] = b;
          seq_cnt    = 2'd1;
          seq_len    = (b >= LeadFour) ? 3'd4 : (b >= LeadThree) ? 3'd3 : 3'd2;
          cp_acc     = 21'(b & (8'h7F >> seq_len));
        end else begin
          run_q.insert(run_q.size(), CharUnderscore);
        end
      end

      for (k = 0; k < run_q.size(); k++) begin
        ent.out_byte   = run_q[k];
        ent.run_last   = (k == run_q.size() - 1);
        ent.string_end = ent.run_last && fin;
        owed_bytes.insert(owed_bytes.size(), ent);
      end
      if (fin) begin
        seq_cnt = '0; seq_len = '0; cp_acc = '0;
      end
    endfunction

    // Accepted output transaction: compare with the oldest owed byte.
    function void match_byte(out_item_t got);
      out_item_t want;
      if (owed_bytes.size() == 0) begin
        $error("unexpected output transaction: out_byte=%02h", got.out_byte);
        fails++;
        return;
      end
      want = owed_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
        fails++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %0b, actual %0b", want.run_last, got.run_last);
        fails++;
      end
      if (got.string_end !== want.string_end) begin
        $error("string_end: expected %0b, actual %0b", want.string_end, got.string_end);
        fails++;
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset and DUT
  // -------------------------------------------------------------------------
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  escape_tracker trk;
  int            burst_left;
  int            bytes_sent;
  int            cycle_cnt  = 0;
  rx_mode_e      rx_mode    = RxFree;
  int            rx_span    = 0;

  always begin
    #(ClkHalf) clk_i = 1'b1;
    #(ClkHalf) clk_i = 1'b0;
  end

  utf8_sanitize_escape DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: switches between free flow, random stalls and a fixed
  // two-of-three pattern, so stalls hit every point of a multi-byte run.
  always @(posedge clk_i) begin
    if (rx_span == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 2));
      rx_span <= $urandom_range(10, 60);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_mode)
      RxFree:     out_ready_i <= 1'b1;
      RxRandom:   out_ready_i <= ($urandom_range(0, 99) < 60);
      RxPeriodic: out_ready_i <= (rx_span % 3 != 0);
      default:    out_ready_i <= 1'b1;
    endcase
  end

  // Monitor: values are sampled before this edge's updates land, so both
  // transactions are seen exactly as the DUT saw them.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) trk.take_byte(in_data_i);
      if (out_valid_o && out_ready_i) trk.match_byte(out_data_o);
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------

  // One input transaction. Valid stays up across a burst; at the end of a
  // burst it drops for a random gap.
  task automatic push_byte(input logic [7:0] b, input logic fin);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= '{in_byte: b, name_end: fin};
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(0, 30);
    end else begin
      burst_left--;
    end
  endtask

  // Directed: byte extremes, every escape class and each broken-sequence case.
  task automatic run_directed();
    push_byte(8'h00, 1'b0);            // lowest control byte
    push_byte(CharBackslash, 1'b0);
    push_byte(CharNewline, 1'b0);
    push_byte(CharPipe, 1'b0);
    push_byte(CharDel, 1'b0);
    push_byte(8'h80, 1'b0);            // stray continuation
    push_byte(8'hFF, 1'b1);            // invalid lead, also closes the name
    push_byte(8'hC3, 1'b0);            // valid two-byte
    push_byte(8'hA9, 1'b0);
    push_byte(8'hF0, 1'b0);            // valid four-byte
    push_byte(8'h9F, 1'b0);
    push_byte(8'h98, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hC0, 1'b0);            // overlong two-byte
    push_byte(8'h80, 1'b0);
    push_byte(8'hED, 1'b0);            // surrogate
    push_byte(8'hA0, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hF4, 1'b0);            // above the code space, ends the name
    push_byte(8'h90, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'hF0, 1'b0);            // interrupted by plain ASCII
    push_byte(8'h9F, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'hE2, 1'b0);            // truncated by the end of the name
    push_byte(8'h82, 1'b1);
    push_byte(8'hC3, 1'b1);            // lead byte as the final byte
  endtask

  // One random name: mostly complete sequences with random payload, plus
  // ASCII, broken sequences and raw noise. The last byte carries name_end.
  task automatic send_name();
    logic [7:0] name_q [$];
    int         segs;
    int         pick;
    int         len;
    int         conts;
    int         k;
    segs = $urandom_range(1, 8);
    repeat (segs) begin
      pick = $urandom_range(0, 99);
      len  = $urandom_range(2, 4);
      if (pick < 55 || pick >= 75 && pick < 88) begin
        case (len)
          2:       name_q.insert(name_q.size(), LeadTwo   | 8'($urandom_range(0, 31)));
          3:       name_q.insert(name_q.size(), LeadThree | 8'($urandom_range(0, 15)));
          default: name_q.insert(name_q.size(), LeadFour  | 8'($urandom_range(0, 4)));
        endcase
        // broken sequences stop short, so the next segment interrupts them
        conts = (pick < 55) ? len - 1 : $urandom_range(0, len - 2);
        for (k = 0; k < conts; k++) begin
          name_q.insert(name_q.size(), ContBase | 8'($urandom_range(0, 63)));
        end
      end else if (pick < 75) begin
        case ($urandom_range(0, 5))
          0:       name_q.insert(name_q.size(), CharBackslash);
          1:       name_q.insert(name_q.size(), CharNewline);
          2:       name_q.insert(name_q.size(), CharPipe);
          default: name_q.insert(name_q.size(), 8'($urandom_range(0, 127)));
        endcase
      end else begin
        name_q.insert(name_q.size(), 8'($urandom_range(0, 255)));
      end
    end
    for (k = 0; k < name_q.size(); k++) push_byte(name_q[k], k == name_q.size() - 1);
  endtask

  initial begin
    trk        = new();
    burst_left = $urandom_range(0, 30);
    bytes_sent = 0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    while (bytes_sent < NumItems) send_name();

    // Stop sending and let the output drain.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (trk.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (trk.pending() != 0) begin
      $error("%0d predicted output bytes never arrived", trk.pending());
    end
    if (trk.fails == 0 && trk.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
